/* rtl/mep_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time palette block.
// No dependencies; imported by every module of the block.
package mep_pkg;

	// digit width of the serial multipliers
	localparam int CHUNK_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int LIMIT_W    = 13;
	localparam int PAL_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 13'd192;
	localparam logic [PAL_W-1:0]   MULT_RST   = 8'd5;
	localparam logic [PAL_W-1:0]   OFFSET_RST = 8'd0;

	// ANSI 256-colour cube
	localparam logic [PAL_W-1:0] PAL_SIZE = 8'd216;
	localparam logic [PAL_W-1:0] PAL_BASE = 8'd16;

	// palette terms already reduced mod 216
	typedef struct packed {
		logic [PAL_W-1:0] mul_mod;
		logic [PAL_W-1:0] off_mod;
	} mep_pal_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mep_fifo_st_t;

	function automatic logic [PAL_W-1:0] mod_pal(input logic [PAL_W-1:0] v);
		return (v >= PAL_SIZE) ? v - PAL_SIZE : v;
	endfunction

endpackage

/* rtl/mep_fifo.sv */
// Small register queue between the front end and the iteration engine.
// Depends on mep_pkg for the status struct.
module mep_fifo #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       wr_data,
	input  logic                   pop,
	output logic [WIDTH-1:0]       rd_data,
	output mep_pkg::mep_fifo_st_t  st
);
	import mep_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign st.full  = (count_q == CNT_W'(DEPTH));
	assign st.empty = (count_q == '0);
	assign do_push  = push && !st.full;
	assign do_pop   = pop && !st.empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		st.full |-> !push)
		else $error("push into full queue");

endmodule

/* rtl/mep_mul.sv */
// Digit-serial unsigned multiplier: one 16-bit digit of b per cycle, MSB first.
// Depends on mep_pkg for the digit width.
module mep_mul #(
	parameter int A_W = 46
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [A_W-1:0]       a,
	input  logic [A_W-1:0]       b,
	output logic                 done,
	output logic [((A_W + mep_pkg::CHUNK_W - 1) / mep_pkg::CHUNK_W) * mep_pkg::CHUNK_W
		+ A_W - 1:0] p
);
	import mep_pkg::*;

	localparam int NCH   = (A_W + CHUNK_W - 1) / CHUNK_W;
	localparam int BW    = NCH * CHUNK_W;
	localparam int PW    = BW + A_W;
	localparam int CNT_W = $clog2(NCH + 1);

	logic [A_W-1:0]         a_q;
	logic [BW-1:0]          b_q;
	logic [A_W+CHUNK_W-1:0] pp_q;
	logic [PW-1:0]          acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   pp_vld_q;
	logic                   done_q;

	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BW'(b);
			acc_q <= '0;
		end else begin
			if (cnt_q != '0) begin
				pp_q <= a_q * b_q[BW-1 -: CHUNK_W];
				b_q  <= b_q << CHUNK_W;
			end
			if (pp_vld_q) begin
				acc_q <= {acc_q[PW-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PW'(pp_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pp_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else if (start) begin
			cnt_q    <= CNT_W'(NCH);
			pp_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			pp_vld_q <= (cnt_q != '0);
			// last partial product lands in acc at this edge
			done_q   <= pp_vld_q && (cnt_q == '0);
		end
	end

endmodule

/* rtl/mep_front.sv */
// Front end: configuration registers, input transactions, per-point job setup.
// Depends on mep_pkg; feeds mep_fifo.
module mep_front #(
	parameter int COORD_WIDTH    = 48,
	parameter int MAX_ITERATIONS = 4096,
	parameter int ITER_W         = 13,
	parameter int ENTRY_W        = 125
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mep_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COORD_WIDTH-1:0]    point_real,
	input  logic signed [COORD_WIDTH-1:0]    point_imag,
	input  mep_pkg::mep_fifo_st_t            fifo_st,
	output logic                             push,
	output logic [ENTRY_W-1:0]               entry
);
	import mep_pkg::*;

	localparam int CMP_W = (ITER_W > LIMIT_W) ? ITER_W : LIMIT_W;

	logic [LIMIT_W-1:0] limit_q;
	logic [PAL_W-1:0]   mult_q;
	logic [PAL_W-1:0]   offset_q;
	logic [CMP_W-1:0]   limit_ext, max_ext;
	logic [ITER_W-1:0]  lim;
	mep_pal_t           pal;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RST;
			mult_q   <= MULT_RST;
			offset_q <= OFFSET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIMIT:  limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_MULT:   mult_q   <= cfg_data[PAL_W-1:0];
				REG_OFFSET: offset_q <= cfg_data[PAL_W-1:0];
				default: ;
			endcase
		end
	end

	// limit saturates at the build-time maximum
	assign limit_ext = CMP_W'(limit_q);
	assign max_ext   = CMP_W'(MAX_ITERATIONS);
	assign lim       = ITER_W'((limit_ext > max_ext) ? max_ext : limit_ext);

	assign pal.mul_mod = mod_pal(mult_q);
	assign pal.off_mod = mod_pal(offset_q);

	assign in_ready = !fifo_st.full;
	assign push     = in_valid && !fifo_st.full;
	assign entry    = {point_real, point_imag, lim, pal};

endmodule

/* rtl/mep_back.sv */
// Iteration engine: runs z = z*z + c on three digit-serial multipliers and
// maps the escape count to a palette index. Depends on mep_pkg and mep_mul.
module mep_back #(
	parameter int COORD_WIDTH = 48,
	parameter int ITER_W      = 13,
	parameter int ENTRY_W     = 125
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mep_pkg::mep_fifo_st_t         fifo_st,
	output logic                          pop,
	input  logic [ENTRY_W-1:0]            entry,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mep_pkg::PAL_W-1:0]     colour_index
);
	import mep_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int F   = W - 4;
	localparam int MW  = W - 2;
	localparam int NCH = (MW + CHUNK_W - 1) / CHUNK_W;
	localparam int PW  = NCH * CHUNK_W + MW;
	localparam int PAL_BITS = $bits(mep_pal_t);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_START = 2'd1;
	localparam logic [1:0] S_MUL   = 2'd2;
	localparam logic [1:0] S_CHECK = 2'd3;

	// |z| parts are held to +-2.0
	localparam logic signed [W+1:0] LIM_WIDE = (W+2)'(1) << (W - 3);
	localparam logic signed [W-1:0] LIM_Z    = W'(1) << (W - 3);
	localparam logic [W:0]          FOUR     = (W+1)'(1) << (W - 2);

	logic [1:0]             state_q;
	logic signed [W-1:0]    zx_q, zy_q, c_re_q, c_im_q;
	logic [W-1:0]           x2_q, y2_q;
	logic signed [W:0]      xy_q;
	logic [ITER_W-1:0]      i_q, lim_q;
	logic [PAL_W-1:0]       mm_q, acc_q, colour_q;
	logic                   out_valid_q;

	mep_pal_t               e_pal;
	logic                   mul_start;
	logic                   xx_done, yy_done, xy_done;
	logic [PW-1:0]          p_xx, p_yy, p_xy;
	logic [MW-1:0]          mag_x, mag_y;
	logic signed [PW:0]     sxy, xy_sh;
	logic signed [W+1:0]    sum_re, sum_im;
	logic [W:0]             mag2;
	logic                   esc, at_lim, fin, out_free;
	logic [PAL_W:0]         acc_sum;
	logic [PAL_W-1:0]       acc_n;

	function automatic logic [MW-1:0] mag(input logic signed [W-1:0] v);
		logic [W-1:0] n;
		n = v[W-1] ? -v : v;
		return n[MW-1:0];
	endfunction

	function automatic logic signed [W-1:0] clamp2(input logic signed [W+1:0] v);
		if (v > LIM_WIDE) begin
			return LIM_Z;
		end else if (v < -LIM_WIDE) begin
			return -LIM_Z;
		end
		return v[W-1:0];
	endfunction

	assign e_pal     = entry[PAL_BITS-1:0];
	assign pop       = (state_q == S_IDLE) && !fifo_st.empty;
	assign mul_start = (state_q == S_START);
	assign mag_x     = mag(zx_q);
	assign mag_y     = mag(zy_q);

	mep_mul #(.A_W(MW)) u_mul_xx (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mag_x), .b(mag_x), .done(xx_done), .p(p_xx)
	);
	mep_mul #(.A_W(MW)) u_mul_yy (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mag_y), .b(mag_y), .done(yy_done), .p(p_yy)
	);
	mep_mul #(.A_W(MW)) u_mul_xy (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mag_x), .b(mag_y), .done(xy_done), .p(p_xy)
	);

	// 2*zx*zy: signed product, floor shift by F-1
	assign sxy   = (zx_q[W-1] ^ zy_q[W-1]) ? -$signed({1'b0, p_xy}) : $signed({1'b0, p_xy});
	assign xy_sh = sxy >>> (F - 1);

	assign sum_re = $signed({2'b00, x2_q}) - $signed({2'b00, y2_q})
		+ $signed({{2{c_re_q[W-1]}}, c_re_q});
	assign sum_im = $signed({xy_q[W], xy_q}) + $signed({{2{c_im_q[W-1]}}, c_im_q});

	assign mag2     = {1'b0, x2_q} + {1'b0, y2_q};
	assign esc      = (mag2 >= FOUR);
	assign at_lim   = (i_q == lim_q);
	assign fin      = at_lim || esc;
	assign out_free = !out_valid_q || out_ready;

	// running (count*mult + offset) mod 216
	assign acc_sum = {1'b0, acc_q} + {1'b0, mm_q};
	assign acc_n   = (acc_sum >= {1'b0, PAL_SIZE}) ? acc_sum[PAL_W-1:0] - PAL_SIZE
		: acc_sum[PAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_CHECK) && fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_MUL;
				S_MUL: begin
					if (xx_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!fin) begin
						state_q <= S_START;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					c_re_q <= entry[ENTRY_W-1 -: W];
					c_im_q <= entry[ENTRY_W-W-1 -: W];
					lim_q  <= entry[PAL_BITS+ITER_W-1 -: ITER_W];
					mm_q   <= e_pal.mul_mod;
					acc_q  <= e_pal.off_mod;
					zx_q   <= '0;
					zy_q   <= '0;
					i_q    <= '0;
				end
			end
			S_MUL: begin
				if (xx_done) begin
					x2_q <= W'(p_xx >> F);
					y2_q <= W'(p_yy >> F);
					xy_q <= xy_sh[W:0];
				end
			end
			S_CHECK: begin
				if (!fin) begin
					zx_q  <= clamp2(sum_re);
					zy_q  <= clamp2(sum_im);
					i_q   <= i_q + 1'b1;
					acc_q <= acc_n;
				end else if (out_free) begin
					colour_q <= at_lim ? '0 : PAL_BASE + acc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign colour_index = colour_q;

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(xx_done == yy_done) && (xx_done == xy_done))
		else $error("multipliers out of step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (i_q <= lim_q))
		else $error("iteration count past limit");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (acc_q < PAL_SIZE))
		else $error("palette accumulator out of range");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHECK) && fin && !out_free) |=> (state_q == S_CHECK))
		else $error("finished point dropped while output busy");

	a_z_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) |-> ((zx_q <= LIM_Z) && (zx_q >= -LIM_Z)
			&& (zy_q <= LIM_Z) && (zy_q >= -LIM_Z)))
		else $error("z outside +-2.0");

endmodule

/* rtl/mandelbrot_escape_palette.sv */
// Top level of the Mandelbrot escape-time palette block.
// Depends on mep_pkg, mep_front, mep_fifo and mep_back.
//
// Each input transaction carries one point c (signed Q4.(COORD_WIDTH-4)) and
// yields one output transaction: colour 0 if the point does not escape within
// the iteration limit, else 16 + ((count*multiplier + offset) mod 216). Every
// iteration of the engine runs the three 16-bit digit-serial multipliers that
// form zx^2, zy^2 and zx*zy. A two-entry queue takes new points while one is
// being iterated, and the result sits in an output register until taken.
// Configuration writes are always accepted and must only be issued while idle.
module mandelbrot_escape_palette #(
	parameter int COORD_WIDTH    = 48,
	parameter int MAX_ITERATIONS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   point_real,
	input  logic signed [COORD_WIDTH-1:0]   point_imag,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mep_pkg::PAL_W-1:0]       colour_index
);
	import mep_pkg::*;

	localparam int ITER_W  = $clog2(MAX_ITERATIONS + 1);
	localparam int ENTRY_W = 2 * COORD_WIDTH + ITER_W + $bits(mep_pal_t);

	mep_fifo_st_t       fifo_st;
	logic               push, pop;
	logic [ENTRY_W-1:0] entry_in, entry_out;

	mep_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.MAX_ITERATIONS(MAX_ITERATIONS),
		.ITER_W(ITER_W),
		.ENTRY_W(ENTRY_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_real(point_real),
		.point_imag(point_imag),
		.fifo_st(fifo_st),
		.push(push),
		.entry(entry_in)
	);

	mep_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(entry_in),
		.pop(pop),
		.rd_data(entry_out),
		.st(fifo_st)
	);

	mep_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.ITER_W(ITER_W),
		.ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fifo_st(fifo_st),
		.pop(pop),
		.entry(entry_out),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.colour_index(colour_index)
	);

endmodule
